### hdl/pow2_size_class_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the power-of-two size-class block allocator
// Shared wrappers that clock the checks on clk_i and report through $error.
// ----------------------------------------------------------------------------
`ifndef POW2_SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH
`define POW2_SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH

// Checked only while out of reset.
`define P2SBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define P2SBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/p2sba_pkg.sv
// ----------------------------------------------------------------------------
// p2sba_pkg
// Widths, operation codes, link memory request type and the size-class
// function shared by the allocator, its link memory and its checker.
// ----------------------------------------------------------------------------
package p2sba_pkg;

  // Fixed field widths.
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned SIZE_W     = 17;
  localparam int unsigned CLS_W      = 5;
  localparam int unsigned LINK_W     = ADDR_W + 1;
  localparam int unsigned LINK_DEPTH = 1 << ADDR_W;
  localparam int unsigned MAX_CLASS  = SIZE_W;

  // Defaults for the top-level parameters.
  localparam int unsigned HEAP_BLOCKS_DEF = 65536;
  localparam int unsigned NUM_CLASSES_DEF = 17;

  // Operation codes.
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  // One access to the link memory.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [LINK_W-1:0] wdata;
  } link_req_t;

  // Ceiling log2 of the size, with a size of zero treated as one.
  function automatic logic [CLS_W-1:0] class_of(logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] m;
    logic [CLS_W-1:0]  c;
    m = (size <= SIZE_W'(1)) ? '0 : size - SIZE_W'(1);
    c = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (m[i]) begin
        c = CLS_W'(i + 1);
      end
    end
    return c;
  endfunction

endpackage

### hdl/p2sba_link_mem.sv
// ----------------------------------------------------------------------------
// p2sba_link_mem
// Next-link store, one entry per block address, with a registered read port.
// ----------------------------------------------------------------------------
module p2sba_link_mem
  import p2sba_pkg::*;
(
  input  logic              clk_i,
  input  link_req_t         req_i,
  output logic [LINK_W-1:0] rdata_o
);

  logic [LINK_W-1:0] mem_q [LINK_DEPTH];
  logic [LINK_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/pow2_size_class_block_allocator.sv
// ----------------------------------------------------------------------------
// pow2_size_class_block_allocator
// Segregated power-of-two free-list allocator over a heap of blocks.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_ready_o operation, size_blocks, free_address
// out      output     out_valid_o/out_ready_i granted_address, size_class,
//                                             out_of_memory
//
// A free, a bump allocation and a refused allocation pass through capture,
// then an execute step that updates the heads and loads the output register.
// A pop from a free list adds a pop step, since the next link comes from the
// synchronous link memory in the cycle after its read.
// Reset clears the bump pointer and all list-head valid bits; the link memory
// is not cleared. A stalled output holds the block in its execute or pop step.
// ----------------------------------------------------------------------------
module pow2_size_class_block_allocator
  import p2sba_pkg::*;
#(
  parameter int unsigned HEAP_BLOCKS = HEAP_BLOCKS_DEF,
  parameter int unsigned NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [SIZE_W-1:0] size_blocks_i,
  input  logic [ADDR_W-1:0] free_address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] granted_address_o,
  output logic [CLS_W-1:0]  size_class_o,
  output logic              out_of_memory_o
);

  localparam int unsigned BT_W   = $clog2(HEAP_BLOCKS + 1);
  localparam int unsigned RND_W  = MAX_CLASS + 1;
  localparam int unsigned SUM_W  = ((BT_W > RND_W) ? BT_W : RND_W) + 1;
  localparam int unsigned CIDX_W = $clog2(NUM_CLASSES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_POP  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Captured request.
  logic              op_q;
  logic [CLS_W-1:0]  cls_q;
  logic [ADDR_W-1:0] addr_q;

  // Allocator state.
  logic [BT_W-1:0]   bump_top_q, bump_top_d;
  logic              bump_we;
  logic              head_valid_q [NUM_CLASSES];
  logic [ADDR_W-1:0] head_addr_q  [NUM_CLASSES];
  logic              head_we;
  logic              head_wv;
  logic [ADDR_W-1:0] head_wa;

  // Output register.
  logic              out_valid_q;
  logic [ADDR_W-1:0] out_granted_q, out_granted_d;
  logic [CLS_W-1:0]  out_cls_q;
  logic              out_oom_q, out_oom_d;
  logic              out_load;
  logic              out_free;

  // Link memory.
  link_req_t         link_req;
  logic [LINK_W-1:0] link_rdata;

  logic              accept;
  logic              cls_ok;
  logic [CIDX_W-1:0] cls_idx;
  logic              head_v;
  logic [ADDR_W-1:0] head_a;
  logic [SUM_W-1:0]  bump_sum;
  logic              bump_fits;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Class lookup for the captured request.
  assign cls_ok    = {1'b0, cls_q} < (CLS_W + 1)'(NUM_CLASSES);
  assign cls_idx   = cls_q[CIDX_W-1:0];
  assign head_v    = cls_ok && head_valid_q[cls_idx];
  assign head_a    = head_addr_q[cls_idx];
  assign bump_sum  = SUM_W'(bump_top_q) + (SUM_W'(1) << cls_q);
  assign bump_fits = bump_sum <= SUM_W'(HEAP_BLOCKS);

  // Sequencer and update decisions.
  always_comb begin
    state_d       = state_q;
    link_req      = '0;
    head_we       = 1'b0;
    head_wv       = 1'b0;
    head_wa       = addr_q;
    bump_we       = 1'b0;
    bump_top_d    = BT_W'(bump_sum);
    out_load      = 1'b0;
    out_granted_d = '0;
    out_oom_d     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_q == OP_ALLOC && head_v) begin
          link_req.re   = 1'b1;
          link_req.addr = head_a;
          state_d       = S_POP;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (op_q == OP_ALLOC) begin
            if (cls_ok && bump_fits) begin
              out_granted_d = ADDR_W'(bump_top_q);
              bump_we       = 1'b1;
            end else begin
              out_oom_d = 1'b1;
            end
          end else if (cls_ok) begin
            // Push: the old head becomes the freed block's next link.
            link_req.we    = 1'b1;
            link_req.addr  = addr_q;
            link_req.wdata = {head_v, head_a};
            head_we        = 1'b1;
            head_wv        = 1'b1;
            head_wa        = addr_q;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_granted_d = head_a;
          head_we       = 1'b1;
          head_wv       = link_rdata[LINK_W-1];
          head_wa       = link_rdata[ADDR_W-1:0];
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bump_top_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_valid_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (bump_we) begin
        bump_top_q <= bump_top_d;
      end
      if (head_we) begin
        head_valid_q[cls_idx] <= head_wv;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      cls_q  <= class_of(size_blocks_i);
      addr_q <= free_address_i;
    end
    if (head_we) begin
      head_addr_q[cls_idx] <= head_wa;
    end
    if (out_load) begin
      out_granted_q <= out_granted_d;
      out_cls_q     <= cls_q;
      out_oom_q     <= out_oom_d;
    end
  end

  p2sba_link_mem u_link_mem (
    .clk_i   (clk_i),
    .req_i   (link_req),
    .rdata_o (link_rdata)
  );

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_granted_q;
  assign size_class_o      = out_cls_q;
  assign out_of_memory_o   = out_oom_q;

endmodule

### hdl/p2sba_checker.sv
// ----------------------------------------------------------------------------
// p2sba_checker
// Port-level checks on the allocator, bound to its top level.
// ----------------------------------------------------------------------------
`include "pow2_size_class_block_allocator_macros.svh"

module p2sba_checker
  import p2sba_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [ADDR_W-1:0] granted_address_o,
  input logic [CLS_W-1:0]  size_class_o,
  input logic              out_of_memory_o
);

  logic                    in_xfer;
  logic                    out_stall;
  logic                    oom_shown;
  logic [ADDR_W+CLS_W:0]   out_fields;

  // Shorthands for the handshake states and the result payload.
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_stall  = out_valid_o && !out_ready_i;
  assign oom_shown  = out_valid_o && out_of_memory_o;
  assign out_fields = {granted_address_o, size_class_o, out_of_memory_o};

  // A stalled result keeps its fields.
  `P2SBA_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(out_fields), "result changed")

  // A refused allocation hands out no address.
  `P2SBA_ASSERT(a_oom_zero, oom_shown |-> granted_address_o == '0, "address on refusal")

  // One request at a time: a transfer in closes the input for the next cycle.
  `P2SBA_ASSERT(a_one_at_a_time, in_xfer |=> !in_ready_o, "input open after a transfer")

  // A cycle spent in reset leaves no result showing at the next edge.
  `P2SBA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind pow2_size_class_block_allocator p2sba_checker u_p2sba_checker (.*);

### verif/pow2_size_class_block_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power-of-two size-class block allocator testbench
// Drives allocate and free requests into the block and predicts every result
// from a local copy of the bump pointer, the per-class free lists and the
// link memory. Results are checked field by field in order under random
// sender gaps, receiver stalls and long output back-pressure.
// ----------------------------------------------------------------------------
module pow2_size_class_block_allocator_test;
  import p2sba_pkg::*;

  localparam int unsigned HEAP_LIMIT = HEAP_BLOCKS_DEF;
  localparam int unsigned NUM_LISTS  = NUM_CLASSES_DEF;
  localparam int unsigned SIZE_TOP   = (1 << SIZE_W) - 1;
  localparam int unsigned ADDR_TOP   = (1 << ADDR_W) - 1;

  // Fields of one result transfer.
  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    logic [CLS_W-1:0]  size_class;
    logic              out_of_memory;
  } alloc_result_t;

  // A block handed out and not yet given back.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] blocks;
  } live_block_t;

  typedef enum logic [1:0] {
    READY_STEADY,
    READY_RANDOM,
    READY_PATTERN
  } ready_mode_e;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic              operation_i    = 1'b0;
  logic [SIZE_W-1:0] size_blocks_i  = '0;
  logic [ADDR_W-1:0] free_address_i = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [ADDR_W-1:0] granted_address_o;
  logic [CLS_W-1:0]  size_class_o;
  logic              out_of_memory_o;

  // Predicted allocator state.
  logic [SIZE_W-1:0] heap_top;
  logic              list_valid [NUM_LISTS];
  logic [ADDR_W-1:0] list_head  [NUM_LISTS];
  logic [LINK_W-1:0] next_free  [LINK_DEPTH];

  alloc_result_t expected_results [$];
  live_block_t   live_blocks [$];
  int unsigned   error_count = 0;

  // Sender burst control and receiver hold-off request.
  bit          gaps_enabled = 1'b1;
  int unsigned burst_left   = 0;
  int unsigned ready_hold_request = 0;

  pow2_size_class_block_allocator u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .size_blocks_i     (size_blocks_i),
    .free_address_i    (free_address_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .granted_address_o (granted_address_o),
    .size_class_o      (size_class_o),
    .out_of_memory_o   (out_of_memory_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Ceiling log2 of the request, with zero counted as one block.
  function automatic int unsigned size_class_of(logic [SIZE_W-1:0] blocks);
    int unsigned need;
    int unsigned cls;
    need = (blocks == '0) ? 1 : int'(blocks);
    cls = 0;
    while (cls < 31 && (32'd1 << cls) < need) begin
      cls++;
    end
    return cls;
  endfunction

  // Apply one accepted request to the predicted state and return its result.
  function automatic alloc_result_t predict_response(op_e op, logic [SIZE_W-1:0] blocks,
                                                    logic [ADDR_W-1:0] addr);
    alloc_result_t     res;
    int unsigned       cls;
    logic [LINK_W-1:0] link;
    longint unsigned   span;
    cls = size_class_of(blocks);
    res = '0;
    res.size_class = CLS_W'(cls);
    if (op == OP_ALLOC) begin
      if (cls >= NUM_LISTS) begin
        res.out_of_memory = 1'b1;
      end else if (list_valid[cls]) begin
        res.granted_address = list_head[cls];
        link = next_free[list_head[cls]];
        list_valid[cls] = link[ADDR_W];
        list_head[cls]  = link[ADDR_W-1:0];
      end else begin
        span = longint'(heap_top) + (longint'(1) << cls);
        if (span > HEAP_LIMIT) begin
          res.out_of_memory = 1'b1;
        end else begin
          res.granted_address = heap_top[ADDR_W-1:0];
          heap_top = SIZE_W'(span);
        end
      end
    end else if (cls < NUM_LISTS) begin
      next_free[addr] = {list_valid[cls], list_head[cls]};
      list_valid[cls] = 1'b1;
      list_head[cls]  = addr;
    end
    return res;
  endfunction

  // Offer one request, wait for its transfer and record the expected result.
  task automatic send_request(input op_e op, input logic [SIZE_W-1:0] blocks,
                              input logic [ADDR_W-1:0] addr, output alloc_result_t predicted);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_enabled && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
      end
    end
    burst_left--;
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    size_blocks_i  <= blocks;
    free_address_i <= addr;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    predicted = predict_response(op, blocks, addr);
    expected_results.push_back(predicted);
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly small sizes, with a thin tail of larger ones.
  function automatic logic [SIZE_W-1:0] pick_request_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return SIZE_W'($urandom_range(1, 16));
    end else if (r < 92) begin
      return SIZE_W'($urandom_range(17, 128));
    end else if (r < 99) begin
      return SIZE_W'($urandom_range(129, 1024));
    end
    return SIZE_W'($urandom_range(1025, 8192));
  endfunction

  // Well-formed allocate/free traffic, optionally mixed with stray requests.
  task automatic send_random_request(input bit with_noise);
    alloc_result_t     got;
    live_block_t       blk;
    op_e               op;
    logic [SIZE_W-1:0] blocks;
    logic [ADDR_W-1:0] addr;
    int unsigned       pick;
    int unsigned       idx;
    pick = $urandom_range(0, 99);
    addr = ADDR_W'($urandom);
    if (with_noise && pick < 12) begin
      // Free of an arbitrary address with an arbitrary size.
      op = OP_FREE;
      blocks = SIZE_W'($urandom_range(0, SIZE_TOP));
    end else if (with_noise && pick < 25) begin
      // Allocation of an arbitrary size, often beyond the lists.
      op = OP_ALLOC;
      blocks = ($urandom_range(0, 3) == 0) ? '0 : SIZE_W'($urandom_range(0, SIZE_TOP));
    end else if (live_blocks.size() != 0 &&
                 ($urandom_range(0, 1) == 1 || live_blocks.size() > 48)) begin
      op = OP_FREE;
      idx = $urandom_range(0, live_blocks.size() - 1);
      blk = live_blocks[idx];
      live_blocks.delete(idx);
      blocks = blk.blocks;
      addr = blk.addr;
    end else begin
      op = OP_ALLOC;
      blocks = pick_request_size();
    end
    send_request(op, blocks, addr, got);
    if (op == OP_ALLOC && !got.out_of_memory) begin
      blk.addr = got.granted_address;
      blk.blocks = blocks;
      live_blocks.push_back(blk);
    end
  endtask

  // Zero size, field extremes, classes beyond the lists, list pops and unchecked frees.
  task automatic test_directed_corners();
    alloc_result_t r;
    send_request(OP_ALLOC, '0, '0, r);
    send_request(OP_ALLOC, SIZE_W'(1), ADDR_W'(ADDR_TOP), r);
    send_request(OP_ALLOC, SIZE_W'(3), '0, r);
    send_request(OP_ALLOC, SIZE_W'(HEAP_LIMIT), '0, r);
    send_request(OP_ALLOC, SIZE_W'(HEAP_LIMIT + 1), '0, r);
    send_request(OP_ALLOC, SIZE_W'(SIZE_TOP), ADDR_W'(ADDR_TOP), r);
    send_request(OP_FREE, SIZE_W'(SIZE_TOP), ADDR_W'(ADDR_TOP), r);
    send_request(OP_FREE, SIZE_W'(100000), ADDR_W'(16'h1234), r);
    // A full-heap block given back and taken again by a smaller request of its class.
    send_request(OP_FREE, SIZE_W'(HEAP_LIMIT), ADDR_W'(ADDR_TOP), r);
    send_request(OP_ALLOC, SIZE_W'(40000), '0, r);
    send_request(OP_ALLOC, SIZE_W'(HEAP_LIMIT), '0, r);
    // Two entries on the class-zero list, popped in reverse order.
    send_request(OP_FREE, '0, '0, r);
    send_request(OP_FREE, SIZE_W'(1), ADDR_W'(1), r);
    send_request(OP_ALLOC, SIZE_W'(1), '0, r);
    send_request(OP_ALLOC, '0, '0, r);
    send_request(OP_ALLOC, SIZE_W'(1), '0, r);
    // Addresses that were never allocated.
    send_request(OP_FREE, SIZE_W'(2), ADDR_W'(16'hAAAA), r);
    send_request(OP_FREE, SIZE_W'(2), ADDR_W'(16'h5555), r);
    send_request(OP_ALLOC, SIZE_W'(2), '0, r);
    send_request(OP_ALLOC, SIZE_W'(2), '0, r);
    // The same address freed twice.
    send_request(OP_FREE, SIZE_W'(32768), ADDR_W'(16'h0F0F), r);
    send_request(OP_FREE, SIZE_W'(20000), ADDR_W'(16'h0F0F), r);
    send_request(OP_ALLOC, SIZE_W'(32768), '0, r);
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 900; i++) begin
      send_random_request(1'b1);
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    gaps_enabled = 1'b0;
    burst_left = 0;
    ready_hold_request = 300;
    for (int i = 0; i < 40; i++) begin
      send_random_request(1'b0);
    end
    gaps_enabled = 1'b1;
  endtask

  // The sender stops until the block has emptied, then resumes.
  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) begin
      send_random_request(1'b1);
    end
    wait_for_drain();
    for (int i = 0; i < 20; i++) begin
      send_random_request(1'b1);
    end
  endtask

  // Large requests until the heap refuses, then a little traffic after that.
  task automatic test_heap_exhaustion();
    alloc_result_t r;
    for (int i = 0; i < 48; i++) begin
      send_request(OP_ALLOC, SIZE_W'($urandom_range(4096, 16384)), ADDR_W'($urandom), r);
      if (r.out_of_memory) begin
        break;
      end
    end
    send_request(OP_ALLOC, SIZE_W'(HEAP_LIMIT), '0, r);
    for (int i = 0; i < 12; i++) begin
      send_random_request(1'b0);
    end
  endtask

  // Receiver: stall modes that change at random intervals, plus requested hold-offs.
  always @(negedge clk_i) begin
    static ready_mode_e mode = READY_STEADY;
    static int unsigned mode_left = 0;
    static int unsigned hold_left = 0;
    static logic [7:0]  stall_pattern = 8'hFF;
    if (ready_hold_request != 0) begin
      hold_left = ready_hold_request;
      ready_hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode = ready_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 96);
        stall_pattern = 8'($urandom);
      end else begin
        mode_left--;
      end
      case (mode)
        READY_STEADY: begin
          out_ready_i <= 1'b1;
        end
        READY_RANDOM: begin
          out_ready_i <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_ready_i <= stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        end
      endcase
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: granted_address %h size_class %0d out_of_memory %b",
               granted_address_o, size_class_o, out_of_memory_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (granted_address_o !== want.granted_address) begin
          $error("granted_address: expected %h, got %h", want.granted_address,
                 granted_address_o);
          error_count++;
        end
        if (size_class_o !== want.size_class) begin
          $error("size_class: expected %0d, got %0d", want.size_class, size_class_o);
          error_count++;
        end
        if (out_of_memory_o !== want.out_of_memory) begin
          $error("out_of_memory: expected %b, got %b", want.out_of_memory, out_of_memory_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    heap_top = '0;
    for (int c = 0; c < NUM_LISTS; c++) begin
      list_valid[c] = 1'b0;
      list_head[c]  = '0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed_corners();
    test_random_traffic();
    test_output_backpressure();
    test_drain_pause();
    test_heap_exhaustion();

    wait_for_drain();
    repeat (16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10000000;
    $display("FAIL");
    $finish;
  end

endmodule
